[design/dvc_pkg.sv]
// shared types and constants for the differential vector clock
package dvc_pkg;

  // sizes of the clock vector and the last-sent table
  localparam int MAX_PROCESSES = 16;
  localparam int PROC_W        = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = PROC_W + 1;
  localparam int VAL_W         = 31;
  localparam int TBL_AW        = 2 * PROC_W;
  localparam int TBL_DEPTH     = MAX_PROCESSES * MAX_PROCESSES;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_PROCESS   = 2'd1;

  // reset value of process_count
  localparam logic [CNT_W-1:0] PROCESS_COUNT_RESET = CNT_W'(MAX_PROCESSES);

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_RECEIVE = 2'd1,
    CMD_SEND    = 2'd2,
    CMD_NONE    = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    command_t          command;
    logic [PROC_W-1:0] pair_index;
    logic [VAL_W-1:0]  pair_value;
    logic [PROC_W-1:0] dest_process;
  } request_t;

  typedef struct packed {
    logic [PROC_W-1:0] entry_index;
    logic [VAL_W-1:0]  entry_value;
    logic              is_empty;
    logic              is_last;
  } result_t;

endpackage

[design/dvc_sent_table.sv]
// last-sent table: one row per destination, entries reading zero until written
module dvc_sent_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dvc_pkg::TBL_AW-1:0] rd_addr,
  output logic [dvc_pkg::VAL_W-1:0]  rd_data,
  input  logic                       wr_en,
  input  logic [dvc_pkg::TBL_AW-1:0] wr_addr,
  input  logic [dvc_pkg::VAL_W-1:0]  wr_data
);
  import dvc_pkg::*;

  logic [VAL_W-1:0]     mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] valid;
  logic [VAL_W-1:0]     mem_q;
  logic                 valid_q;

  // storage array with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // per-entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  // entries never written read as zero
  assign rd_data = valid_q ? mem_q : '0;

endmodule

[design/differential_vector_clock.sv]
// top level of the differential vector clock
//
// Command channel: a request transfers at a clock edge with start high and
// busy low. command selects a local tick, a receive of one (index, value)
// pair, or a send to dest_process; the unused code is dropped.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 is process_count, index 1 is own_process, others are ignored.
// cfg_ready is always high; write only while busy is low.
// Results come only from a send: each sits on result for one cycle with
// result_valid high, and the receiver cannot stall them. Changed entries
// come out in index order, is_last on the final one; a send with nothing
// changed, or to a destination outside the count, gives one empty marker.
// A tick or receive keeps busy high through ST_UPDATE after the transfer
// (read, then update of one clock entry). A send scans one entry per cycle
// through a single compare unit fed by the clock vector and the last-sent
// table read ports, over the process count in use (capped at 16) in ST_SCAN,
// then ST_DRAIN, ST_FINISH; an out-of-range send goes straight to ST_FINISH.
// Reset clears both stores at once through valid bits, sets process_count
// to 16 and own_process to 0, and the block is ready right after reset.
module differential_vector_clock (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  dvc_pkg::request_t             request,
  output logic                          result_valid,
  output dvc_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dvc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dvc_pkg::*;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]  process_count;
  logic [PROC_W-1:0] own_process;
  logic [CNT_W-1:0]  count_eff;

  command_t          cmd_q;
  logic [PROC_W-1:0] idx_q;
  logic              in_range_q;
  logic [VAL_W-1:0]  pval_q;
  logic [PROC_W-1:0] dest_q;

  logic [PROC_W-1:0] scan_idx;
  logic              scan_done;
  logic              cmp_valid;
  logic [PROC_W-1:0] cmp_idx;

  logic              pend_valid;
  logic [PROC_W-1:0] pend_idx;
  logic [VAL_W-1:0]  pend_val;

  logic              accept;
  logic              dest_ok;

  logic [VAL_W-1:0]  cv_mem [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0] cv_valid;
  logic [VAL_W-1:0]  cv_mem_q;
  logic              cv_valid_q;
  logic [VAL_W-1:0]  cv_rd;
  logic [PROC_W-1:0] cv_raddr;
  logic              cv_we;
  logic [VAL_W-1:0]  cv_wdata;

  logic [VAL_W-1:0]  ls_rd;
  logic              diff;
  logic              emit;
  result_t           emit_data;

  // fsm output decodes
  logic scan_issue;
  logic finishing;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= PROCESS_COUNT_RESET;
      own_process   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROCESS_COUNT: process_count <= cfg_data;
        CFG_OWN_PROCESS:   own_process   <= cfg_data[PROC_W-1:0];
        default: ;
      endcase
    end
  end

  // number of entries in use, capped at the table size
  assign count_eff = (process_count > CNT_W'(MAX_PROCESSES)) ?
                     CNT_W'(MAX_PROCESSES) : process_count;

  assign accept  = start && !busy;
  assign dest_ok = {1'b0, request.dest_process} < count_eff;

  // last scanned index
  assign scan_done = {1'b0, scan_idx} == (count_eff - CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (request.command)
            CMD_TICK:    state_next = ST_UPDATE;
            CMD_RECEIVE: state_next = ST_UPDATE;
            CMD_SEND:    state_next = dest_ok ? ST_SCAN : ST_FINISH;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_UPDATE: state_next = ST_IDLE;
      ST_SCAN:   state_next = scan_done ? ST_DRAIN : ST_SCAN;
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy       = 1'b1;
    scan_issue = 1'b0;
    finishing  = 1'b0;
    case (state)
      ST_IDLE:   busy       = 1'b0;
      ST_SCAN:   scan_issue = 1'b1;
      ST_FINISH: finishing  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the command on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= request.command;
      pval_q <= request.pair_value;
      dest_q <= request.dest_process;
      if (request.command == CMD_TICK) begin
        idx_q      <= own_process;
        in_range_q <= {1'b0, own_process} < count_eff;
      end else begin
        idx_q      <= request.pair_index;
        in_range_q <= {1'b0, request.pair_index} < count_eff;
      end
    end
  end

  // scan counter and compare stage tag
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= scan_issue;
    end
    if (accept) begin
      scan_idx <= '0;
    end else if (scan_issue) begin
      scan_idx <= scan_idx + PROC_W'(1);
    end
    cmp_idx <= scan_idx;
  end

  // clock vector read address
  always_comb begin
    if (state == ST_IDLE) begin
      cv_raddr = (request.command == CMD_TICK) ? own_process : request.pair_index;
    end else begin
      cv_raddr = scan_idx;
    end
  end

  // clock vector update: saturating tick or max-merge, only for an index in range
  always_comb begin
    cv_we    = 1'b0;
    cv_wdata = pval_q;
    if (state == ST_UPDATE && in_range_q) begin
      if (cmd_q == CMD_TICK) begin
        cv_we    = cv_rd != VAL_MAX;
        cv_wdata = cv_rd + VAL_W'(1);
      end else begin
        cv_we    = pval_q > cv_rd;
      end
    end
  end

  // clock vector storage with registered read
  always_ff @(posedge clk) begin
    if (cv_we) begin
      cv_mem[idx_q] <= cv_wdata;
    end
    cv_mem_q <= cv_mem[cv_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_valid   <= '0;
      cv_valid_q <= 1'b0;
    end else begin
      if (cv_we) begin
        cv_valid[idx_q] <= 1'b1;
      end
      cv_valid_q <= cv_valid[cv_raddr];
    end
  end

  assign cv_rd = cv_valid_q ? cv_mem_q : '0;

  // last-sent table
  dvc_sent_table u_sent_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr ({dest_q, scan_idx}),
    .rd_data (ls_rd),
    .wr_en   (diff),
    .wr_addr ({dest_q, cmp_idx}),
    .wr_data (cv_rd)
  );

  // compare one entry against the destination row
  assign diff = cmp_valid && (cv_rd != ls_rd);

  // one changed entry held back so the final one can carry is_last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b0;
    end else if (diff) begin
      pend_valid <= 1'b1;
    end
    if (diff) begin
      pend_idx <= cmp_idx;
      pend_val <= cv_rd;
    end
  end

  // result selection
  always_comb begin
    emit_data.entry_index = pend_idx;
    emit_data.entry_value = pend_val;
    emit_data.is_empty    = 1'b0;
    emit_data.is_last     = 1'b0;
    emit                  = diff && pend_valid;
    if (finishing) begin
      emit              = 1'b1;
      emit_data.is_last = 1'b1;
      if (!pend_valid) begin
        emit_data.entry_index = '0;
        emit_data.entry_value = '0;
        emit_data.is_empty    = 1'b1;
      end
    end
  end

  // registered result port
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
    result <= emit_data;
  end

endmodule

[tb/differential_vector_clock_tb.sv]
// testbench for the differential vector clock: directed command table, then random commands
module differential_vector_clock_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dvc_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 39;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  localparam result_t EMPTY_MARK = '{entry_index: '0, entry_value: '0,
                                     is_empty: 1'b1, is_last: 1'b1};

  // one row of the directed table: a register write or a command
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    request_t              req;
    bit                    pinned;
    result_t               pinned_res;
  } step_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  request_t              request;
  logic                  result_valid;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic [VAL_W-1:0]  clk_vec  [MAX_PROCESSES];
  logic [VAL_W-1:0]  sent_row [MAX_PROCESSES][MAX_PROCESSES];
  logic [CNT_W-1:0]  proc_count;
  logic [PROC_W-1:0] own_idx;

  result_t   pending_entries[$];
  step_row_t directed[$];
  int        idle_pct;
  int        mismatches;
  int        idle_cycles;

  differential_vector_clock u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // entries in use: process_count capped at the table size
  function automatic int entries_in_use();
    return (proc_count > CNT_W'(MAX_PROCESSES)) ? MAX_PROCESSES : int'(proc_count);
  endfunction

  // apply one command to the predicted clock and collect the entries a send emits
  function automatic void step_clock(input request_t req, output result_t produced[$]);
    int      n;
    result_t r;
    n = entries_in_use();
    produced = {};
    case (req.command)
      CMD_TICK: begin
        if (int'(own_idx) < n && clk_vec[own_idx] != VAL_MAX)
          clk_vec[own_idx] = clk_vec[own_idx] + 1'b1;
      end
      CMD_RECEIVE: begin
        if (int'(req.pair_index) < n && req.pair_value > clk_vec[req.pair_index])
          clk_vec[req.pair_index] = req.pair_value;
      end
      CMD_SEND: begin
        if (int'(req.dest_process) < n) begin
          for (int i = 0; i < n; i++) begin
            if (clk_vec[i] != sent_row[req.dest_process][i]) begin
              r = '{entry_index: PROC_W'(i), entry_value: clk_vec[i],
                    is_empty: 1'b0, is_last: 1'b0};
              produced.push_back(r);
              sent_row[req.dest_process][i] = clk_vec[i];
            end
          end
        end
        if (produced.size() == 0) begin
          produced.push_back(EMPTY_MARK);
        end else begin
          r = produced[produced.size()-1];
          r.is_last = 1'b1;
          produced[produced.size()-1] = r;
        end
      end
      default: ;
    endcase
  endfunction

  // random command, mostly aimed at entries in use and at values that move the clock
  function automatic request_t random_request();
    request_t r;
    int       n;
    int       pick;
    n = entries_in_use();
    r.pair_index   = PROC_W'($urandom);
    r.pair_value   = VAL_W'($urandom);
    r.dest_process = PROC_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      r.command = CMD_TICK;
    end else if (pick < 62) begin
      r.command = CMD_RECEIVE;
    end else if (pick < 95) begin
      r.command = CMD_SEND;
    end else begin
      r.command = CMD_NONE;
    end
    if (n > 0 && $urandom_range(9) != 0) begin
      r.pair_index   = PROC_W'($urandom_range(n - 1));
      r.dest_process = PROC_W'($urandom_range(n - 1));
    end
    if (r.command == CMD_RECEIVE) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        if (clk_vec[r.pair_index] >= VAL_MAX - 3)
          r.pair_value = VAL_MAX;
        else
          r.pair_value = clk_vec[r.pair_index] + VAL_W'($urandom_range(1, 3));
      end else if (pick < 8) begin
        r.pair_value = VAL_W'($urandom_range(200));
      end
    end
    return r;
  endfunction

  // table row builders
  function automatic step_row_t row_op(command_t c, logic [PROC_W-1:0] idx,
                                       logic [VAL_W-1:0] val, logic [PROC_W-1:0] dest);
    step_row_t s;
    s = '{is_cfg: 1'b0, cfg_idx: '0, cfg_val: '0,
          req: '{command: c, pair_index: idx, pair_value: val, dest_process: dest},
          pinned: 1'b0, pinned_res: EMPTY_MARK};
    return s;
  endfunction

  function automatic step_row_t row_pin(command_t c, logic [PROC_W-1:0] idx,
                                        logic [VAL_W-1:0] val, logic [PROC_W-1:0] dest,
                                        result_t res);
    step_row_t s;
    s = row_op(c, idx, val, dest);
    s.pinned = 1'b1;
    s.pinned_res = res;
    return s;
  endfunction

  function automatic step_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_row_t s;
    s = row_op(CMD_NONE, '0, '0, '0);
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    return s;
  endfunction

  // one command transfer, with a random gap in front; start stays high afterwards
  task automatic drive_request(input request_t req, input bit pinned, input result_t pin_res);
    result_t produced[$];
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    request <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    step_clock(req, produced);
    if (pinned)
      pending_entries.push_back(pin_res);
    else
      foreach (produced[k]) pending_entries.push_back(produced[k]);
  endtask

  // drop start and wait until the block is idle with nothing outstanding
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write transfer
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PROCESS_COUNT)
      proc_count = val;
    else if (idx == CFG_OWN_PROCESS)
      own_idx = val[PROC_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checking and watchdog
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (result_valid) begin
        if (pending_entries.size() == 0) begin
          $error("unexpected result: entry_index %0d entry_value %0d is_empty %0b is_last %0b",
                 result.entry_index, result.entry_value, result.is_empty, result.is_last);
          mismatches++;
        end else begin
          want = pending_entries.pop_front();
          if (result.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want.entry_index, result.entry_index);
            mismatches++;
          end
          if (result.entry_value !== want.entry_value) begin
            $error("entry_value: expected %0d, got %0d", want.entry_value, result.entry_value);
            mismatches++;
          end
          if (result.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, result.is_empty);
            mismatches++;
          end
          if (result.is_last !== want.is_last) begin
            $error("is_last: expected %0b, got %0b", want.is_last, result.is_last);
            mismatches++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [CFG_DATA_W-1:0] count_pick;
    logic [CFG_DATA_W-1:0] own_pick;
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    idle_pct    = 0;
    mismatches  = 0;
    idle_cycles = 0;
    proc_count  = PROCESS_COUNT_RESET;
    own_idx     = '0;
    foreach (clk_vec[i]) clk_vec[i] = '0;
    foreach (sent_row[i, j]) sent_row[i][j] = '0;

    // after reset: sixteen entries, own process 0, nothing sent yet
    directed.push_back(row_pin(CMD_SEND, 4'd0, '0, 4'd0, EMPTY_MARK));
    directed.push_back(row_pin(CMD_SEND, 4'd0, '0, 4'd15, EMPTY_MARK));
    directed.push_back(row_op(CMD_TICK, 4'd0, '0, 4'd0));
    directed.push_back(row_op(CMD_RECEIVE, 4'd15, VAL_MAX, 4'd0));
    directed.push_back(row_op(CMD_RECEIVE, 4'd5, '0, 4'd0));
    directed.push_back(row_op(CMD_RECEIVE, 4'd3, 31'h2AAAAAAA, 4'd0));
    directed.push_back(row_op(CMD_RECEIVE, 4'd3, 31'h55555555, 4'd0));
    directed.push_back(row_op(CMD_RECEIVE, 4'd10, 31'h2AAAAAAA, 4'd0));
    // unused command with every field bit set
    directed.push_back(row_op(CMD_NONE, 4'd15, VAL_MAX, 4'd15));
    directed.push_back(row_op(CMD_SEND, 4'd0, '0, 4'd7));
    directed.push_back(row_pin(CMD_SEND, 4'd0, '0, 4'd7, EMPTY_MARK));
    // own entry runs into saturation
    directed.push_back(row_op(CMD_RECEIVE, 4'd0, 31'h7FFFFFFE, 4'd0));
    directed.push_back(row_op(CMD_TICK, 4'd0, '0, 4'd0));
    directed.push_back(row_op(CMD_TICK, 4'd0, '0, 4'd0));
    directed.push_back(row_pin(CMD_SEND, 4'd0, '0, 4'd7,
                               '{entry_index: 4'd0, entry_value: VAL_MAX,
                                 is_empty: 1'b0, is_last: 1'b1}));
    // four entries in use, own process outside them
    directed.push_back(row_cfg(CFG_OWN_PROCESS, 5'd15));
    directed.push_back(row_cfg(CFG_PROCESS_COUNT, 5'd4));
    directed.push_back(row_op(CMD_TICK, 4'd0, '0, 4'd0));
    directed.push_back(row_op(CMD_RECEIVE, 4'd9, 31'd5, 4'd0));
    directed.push_back(row_pin(CMD_SEND, 4'd0, '0, 4'd9, EMPTY_MARK));
    directed.push_back(row_op(CMD_SEND, 4'd0, '0, 4'd3));
    // no entry in use; spare register index is ignored
    directed.push_back(row_cfg(CFG_PROCESS_COUNT, 5'd0));
    directed.push_back(row_cfg(CFG_SPARE, 5'd31));
    directed.push_back(row_pin(CMD_SEND, 4'd0, '0, 4'd0, EMPTY_MARK));
    directed.push_back(row_op(CMD_TICK, 4'd0, '0, 4'd0));
    // count above the table size is capped
    directed.push_back(row_cfg(CFG_PROCESS_COUNT, 5'd31));
    directed.push_back(row_op(CMD_TICK, 4'd0, '0, 4'd0));
    directed.push_back(row_op(CMD_RECEIVE, 4'd14, 31'd1, 4'd0));
    directed.push_back(row_op(CMD_SEND, 4'd0, '0, 4'd15));
    // single entry in use
    directed.push_back(row_cfg(CFG_PROCESS_COUNT, 5'd1));
    directed.push_back(row_cfg(CFG_OWN_PROCESS, 5'd0));
    directed.push_back(row_op(CMD_TICK, 4'd0, '0, 4'd0));
    directed.push_back(row_op(CMD_SEND, 4'd0, '0, 4'd0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      if (directed[k].is_cfg) begin
        settle();
        write_register(directed[k].cfg_idx, directed[k].cfg_val);
      end else begin
        drive_request(directed[k].req, directed[k].pinned, directed[k].pinned_res);
      end
    end

    // random phases, each setting the registers and a sender gap rate
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0, 3:    count_pick = 5'd16;
        1:       count_pick = CFG_DATA_W'($urandom_range(2, 15));
        2:       count_pick = 5'd1;
        4:       count_pick = CFG_DATA_W'($urandom_range(1, 16));
        default: count_pick = CFG_DATA_W'($urandom_range(17, 31));
      endcase
      if ($urandom_range(3) != 0)
        own_pick = CFG_DATA_W'($urandom_range((count_pick > 5'd16) ? 15 : count_pick - 1));
      else
        own_pick = CFG_DATA_W'($urandom_range(15));
      write_register(CFG_PROCESS_COUNT, count_pick);
      write_register(CFG_OWN_PROCESS, own_pick);
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 78;
        default: idle_pct = 20;
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off until every outstanding entry has come back
        if (k == PHASE_ITEMS / 2)
          settle();
        drive_request(random_request(), 1'b0, EMPTY_MARK);
      end
    end

    settle();
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
